@@ rtl/vmt_pkg.sv @@
// Shared types, widths and constants of the vertex matrix transform.
package vmt_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;

   localparam int VEC_W = WORD_BITS + 1;
   localparam int WP_W = 2 * WORD_BITS;
   localparam int PROD_W = 2 * WORD_BITS + 1;
   localparam int ACC_W = PROD_W + 3;
   localparam int NUM_W = ACC_W + FRAC_BITS;
   localparam int DEN_W = ACC_W;
   localparam int DSH_W = DEN_W + WORD_BITS + 1;
   localparam int DIV_STAGES = WORD_BITS + 1;

   localparam logic [WORD_BITS-1:0] SMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic [WORD_BITS-1:0] SMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
   localparam logic [WORD_BITS-1:0] ONE =
      (FRAC_BITS <= WORD_BITS - 2) ? WORD_BITS'(64'd1 << FRAC_BITS) : SMAX;

   typedef enum logic [2:0] {
      OP_LOAD        = 3'd0,
      OP_AFFINE      = 3'd1,
      OP_TAFFINE     = 3'd2,
      OP_ROTATE      = 3'd3,
      OP_UNROTATE    = 3'd4,
      OP_UNTRANSFORM = 3'd5,
      OP_PROJECT     = 3'd6
   } op_type;

   typedef struct packed {
      logic                        proj;
      logic                        wzero;
      logic [2:0]                  neg;
      logic [2:0][WORD_BITS-1:0]   res;
      logic                        fault;
   } side_type;

endpackage

@@ rtl/vmt_div_lane.sv @@
// Pipelined restoring divider lane, one quotient bit per stage, with overflow check.
module vmt_div_lane (
   input  logic                             clock,
   input  logic [vmt_pkg::DIV_STAGES-1:0]   stage_en,
   input  logic [vmt_pkg::NUM_W-1:0]        dividend,
   input  logic [vmt_pkg::DEN_W-1:0]        divisor,
   output logic [vmt_pkg::WORD_BITS-1:0]    quotient,
   output logic                             overflow
);
   import vmt_pkg::*;

   logic [NUM_W-1:0]     rem_ff [DIV_STAGES];
   logic [DEN_W-1:0]     den_ff [DIV_STAGES];
   logic [WORD_BITS-1:0] quo_ff [DIV_STAGES];
   logic                 ovf_ff [DIV_STAGES];

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         rem_ff[0] <= dividend;
         den_ff[0] <= divisor;
         quo_ff[0] <= '0;
         ovf_ff[0] <= DSH_W'(dividend) >= (DSH_W'(divisor) << WORD_BITS);
      end
   end

   for (genvar k = 1; k < DIV_STAGES; k++) begin : g_stage
      localparam int B = WORD_BITS - k;
      logic [DSH_W-1:0] trial;
      logic             take;

      assign trial = DSH_W'(rem_ff[k-1]) - (DSH_W'(den_ff[k-1]) << B);
      assign take = ~trial[DSH_W-1];

      always_ff @(posedge clock) begin
         if (stage_en[k]) begin
            rem_ff[k] <= take ? trial[NUM_W-1:0] : rem_ff[k-1];
            den_ff[k] <= den_ff[k-1];
            quo_ff[k] <= quo_ff[k-1] | (WORD_BITS'(take) << B);
            ovf_ff[k] <= ovf_ff[k-1];
         end
      end
   end

   assign quotient = quo_ff[DIV_STAGES-1];
   assign overflow = ovf_ff[DIV_STAGES-1];

endmodule

@@ rtl/vertex_matrix_transform_top.sv @@
// Top level of the 4x4 homogeneous vertex transform with matrix store and pipeline.
//
//   channel   direction   ports                                         transfer when
//   request   in          req_op, req_entry_index, req_entry_value,
//                         req_in_x, req_in_y, req_in_z                  req_valid & req_ready
//   response  out         rsp_out_x, rsp_out_y, rsp_out_z, rsp_fault   rsp_valid & rsp_ready
//
// One request transfer per cycle unless a full, stalled pipeline holds req_ready low.
// Most of the pipeline depth is the divider, which resolves one quotient bit per stage.
// Load requests write the matrix at transfer and produce no response.
// Reset clears all stage valid bits and loads the identity matrix.
// A waiting response only stalls the stages behind it that hold data; empty stages still fill.
module vertex_matrix_transform_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [2:0]                          req_op,
   input  logic [3:0]                          req_entry_index,
   input  logic signed [vmt_pkg::WORD_BITS-1:0] req_entry_value,
   input  logic signed [vmt_pkg::WORD_BITS-1:0] req_in_x,
   input  logic signed [vmt_pkg::WORD_BITS-1:0] req_in_y,
   input  logic signed [vmt_pkg::WORD_BITS-1:0] req_in_z,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [vmt_pkg::WORD_BITS-1:0] rsp_out_x,
   output logic signed [vmt_pkg::WORD_BITS-1:0] rsp_out_y,
   output logic signed [vmt_pkg::WORD_BITS-1:0] rsp_out_z,
   output logic                                rsp_fault
);
   import vmt_pkg::*;

   localparam int S_DIV0 = 4;
   localparam int NSTG = S_DIV0 + DIV_STAGES + 1;
   localparam int LAST = NSTG - 1;
   localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);

   op_type                       op_e;
   logic                         accept;
   logic                         vtx_accept;
   logic [NSTG-1:0]              vld_ff;
   logic [NSTG-1:0]              stage_en;

   logic signed [WORD_BITS-1:0]  mat_ff [16];
   logic signed [WORD_BITS-1:0]  vin [3];

   logic signed [WORD_BITS-1:0]  coef_a_in [3][3];
   logic signed [VEC_W-1:0]      vec_a_in [3];
   logic signed [WORD_BITS-1:0]  tr_a_in [3];
   logic signed [WORD_BITS-1:0]  coef_a_ff [3][3];
   logic signed [VEC_W-1:0]      vec_a_ff [3];
   logic signed [WORD_BITS-1:0]  tr_a_ff [3];
   logic signed [WORD_BITS-1:0]  wc_a_ff [4];
   logic signed [WORD_BITS-1:0]  pos_a_ff [3];
   logic                         proj_a_ff;

   logic signed [PROD_W-1:0]     prod_b_ff [3][3];
   logic signed [WP_W-1:0]       wp_b_ff [3];
   logic signed [WORD_BITS-1:0]  tr_b_ff [3];
   logic signed [WORD_BITS-1:0]  w33_b_ff;
   logic                         proj_b_ff;

   logic signed [ACC_W-1:0]      acc_c_ff [3];
   logic signed [ACC_W-1:0]      wden_c_ff;
   logic                         proj_c_ff;

   logic signed [ACC_W-1:0]      rnd [3];
   logic [ACC_W-1:0]             mag [3];
   logic [ACC_W-1:0]             wmag;
   logic                         fits;
   side_type                     side_d_in;
   side_type                     side_d_ff;
   logic [NUM_W-1:0]             num_d_in [3];
   logic [NUM_W-1:0]             num_d_ff [3];
   logic [DEN_W-1:0]             den_d_ff;

   side_type                     side_ff [DIV_STAGES];
   logic [WORD_BITS-1:0]         quo [3];
   logic                         ovf [3];

   side_type                     fin;
   logic                         big;
   logic [WORD_BITS-1:0]         out_in [3];
   logic                         fault_in;
   logic [WORD_BITS-1:0]         out_ff [3];
   logic                         fault_ff;

   assign op_e = op_type'(req_op);
   assign accept = req_valid && req_ready;
   assign vtx_accept = accept && (op_e inside {OP_AFFINE, OP_TAFFINE, OP_ROTATE,
                                               OP_UNROTATE, OP_UNTRANSFORM, OP_PROJECT});

   always_comb begin
      stage_en[LAST] = !vld_ff[LAST] || rsp_ready;
      for (int s = LAST - 1; s >= 0; s--) begin
         stage_en[s] = !vld_ff[s] || stage_en[s+1];
      end
   end

   assign req_ready = stage_en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (stage_en[0]) begin
            vld_ff[0] <= vtx_accept;
         end
         for (int s = 1; s < NSTG; s++) begin
            if (stage_en[s]) begin
               vld_ff[s] <= vld_ff[s-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int e = 0; e < 16; e++) begin
            mat_ff[e] <= (e % 5 == 0) ? ONE : '0;
         end
      end else if (accept && op_e == OP_LOAD) begin
         mat_ff[req_entry_index] <= req_entry_value;
      end
   end

   // Stage A: select matrix entries and operands for the op.
   always_comb begin
      vin[0] = req_in_x;
      vin[1] = req_in_y;
      vin[2] = req_in_z;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            if (op_e inside {OP_TAFFINE, OP_UNROTATE, OP_UNTRANSFORM}) begin
               coef_a_in[i][j] = mat_ff[j*4+i];
            end else begin
               coef_a_in[i][j] = mat_ff[i*4+j];
            end
         end
         if (op_e == OP_UNTRANSFORM) begin
            vec_a_in[i] = VEC_W'(vin[i]) - VEC_W'(mat_ff[i*4+3]);
         end else begin
            vec_a_in[i] = VEC_W'(vin[i]);
         end
         case (op_e)
            OP_AFFINE, OP_PROJECT: tr_a_in[i] = mat_ff[i*4+3];
            OP_TAFFINE:            tr_a_in[i] = mat_ff[12+i];
            default:               tr_a_in[i] = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         coef_a_ff <= coef_a_in;
         vec_a_ff <= vec_a_in;
         tr_a_ff <= tr_a_in;
         pos_a_ff <= vin;
         for (int j = 0; j < 4; j++) begin
            wc_a_ff[j] <= mat_ff[12+j];
         end
         proj_a_ff <= (op_e == OP_PROJECT);
      end
   end

   // Stage B: all products.
   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               prod_b_ff[i][j] <= PROD_W'(coef_a_ff[i][j]) * PROD_W'(vec_a_ff[j]);
            end
            wp_b_ff[i] <= WP_W'(wc_a_ff[i]) * WP_W'(pos_a_ff[i]);
         end
         tr_b_ff <= tr_a_ff;
         w33_b_ff <= wc_a_ff[3];
         proj_b_ff <= proj_a_ff;
      end
   end

   // Stage C: exact sums.
   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         for (int i = 0; i < 3; i++) begin
            acc_c_ff[i] <= ACC_W'(prod_b_ff[i][0]) + ACC_W'(prod_b_ff[i][1])
                         + ACC_W'(prod_b_ff[i][2]) + (ACC_W'(tr_b_ff[i]) <<< FRAC_BITS);
         end
         wden_c_ff <= ACC_W'(wp_b_ff[0]) + ACC_W'(wp_b_ff[1]) + ACC_W'(wp_b_ff[2])
                    + (ACC_W'(w33_b_ff) <<< FRAC_BITS);
         proj_c_ff <= proj_b_ff;
      end
   end

   // Stage D: rounding and saturation, or divider operands for projection.
   always_comb begin
      side_d_in = '0;
      side_d_in.proj = proj_c_ff;
      side_d_in.wzero = (wden_c_ff == '0);
      wmag = wden_c_ff[ACC_W-1] ? ACC_W'(-wden_c_ff) : ACC_W'(wden_c_ff);
      fits = 1'b1;
      for (int i = 0; i < 3; i++) begin
         rnd[i] = (acc_c_ff[i] + HALF) >>> FRAC_BITS;
         fits = (&rnd[i][ACC_W-1:WORD_BITS-1]) || !(|rnd[i][ACC_W-1:WORD_BITS-1]);
         if (fits) begin
            side_d_in.res[i] = rnd[i][WORD_BITS-1:0];
         end else begin
            side_d_in.res[i] = rnd[i][ACC_W-1] ? SMIN : SMAX;
         end
         side_d_in.fault = side_d_in.fault || !fits;
         side_d_in.neg[i] = acc_c_ff[i][ACC_W-1] ^ wden_c_ff[ACC_W-1];
         mag[i] = acc_c_ff[i][ACC_W-1] ? ACC_W'(-acc_c_ff[i]) : ACC_W'(acc_c_ff[i]);
         num_d_in[i] = {mag[i], {FRAC_BITS{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         side_d_ff <= side_d_in;
         num_d_ff <= num_d_in;
         den_d_ff <= wmag;
      end
   end

   for (genvar g = 0; g < 3; g++) begin : g_lane
      vmt_div_lane u_lane (
         .clock    (clock),
         .stage_en (stage_en[S_DIV0 +: DIV_STAGES]),
         .dividend (num_d_ff[g]),
         .divisor  (den_d_ff),
         .quotient (quo[g]),
         .overflow (ovf[g])
      );
   end

   always_ff @(posedge clock) begin
      if (stage_en[S_DIV0]) begin
         side_ff[0] <= side_d_ff;
      end
      for (int k = 1; k < DIV_STAGES; k++) begin
         if (stage_en[S_DIV0+k]) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // Output stage: for projection, sign and saturate the quotients; else pass the rounded results.
   always_comb begin
      fin = side_ff[DIV_STAGES-1];
      fault_in = fin.fault && !fin.proj;
      big = 1'b0;
      for (int i = 0; i < 3; i++) begin
         out_in[i] = fin.res[i];
         if (fin.proj) begin
            if (fin.wzero) begin
               out_in[i] = '0;
               fault_in = 1'b1;
            end else begin
               big = ovf[i] || (quo[i] > (fin.neg[i] ? SMIN : SMAX));
               if (big) begin
                  out_in[i] = fin.neg[i] ? SMIN : SMAX;
               end else begin
                  out_in[i] = fin.neg[i] ? -quo[i] : quo[i];
               end
               fault_in = fault_in || big;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[LAST]) begin
         out_ff <= out_in;
         fault_ff <= fault_in;
      end
   end

   assign rsp_valid = vld_ff[LAST];
   assign rsp_out_x = out_ff[0];
   assign rsp_out_y = out_ff[1];
   assign rsp_out_z = out_ff[2];
   assign rsp_fault = fault_ff;

   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      (accept && op_e == OP_LOAD) |=> !vld_ff[0])
      else $error("load transfer entered the pipeline");

   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (&vld_ff && !rsp_ready))
      else $error("request stalled with an empty stage");

   a_zero_w_fault: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[LAST-1] && stage_en[LAST] && side_ff[DIV_STAGES-1].proj
       && side_ff[DIV_STAGES-1].wzero)
      |=> (rsp_fault && rsp_out_x == '0 && rsp_out_y == '0 && rsp_out_z == '0))
      else $error("zero w projection without fault");

endmodule

@@ tb/vertex_matrix_transform_top_tb.sv @@
// Self-checking testbench of the vertex matrix transform with a transaction scoreboard.
module vertex_matrix_transform_top_tb;
   import vmt_pkg::*;

   localparam logic [2:0] OP_SPARE = 3'd7;
   localparam int WIDE = 192;

   typedef struct {
      logic signed [WORD_BITS-1:0] x, y, z;
      bit                          f;
   } vertex_result_type;

   class vertex_scoreboard_type;
      logic signed [WORD_BITS-1:0] mat[16];
      vertex_result_type           due[$];
      int                          errors;

      function new();
         for (int i = 0; i < 16; i++) mat[i] = (i % 5 == 0) ? ONE : '0;
         errors = 0;
      endfunction

      function logic signed [WIDE-1:0] ent(int r, int c);
         logic signed [WIDE-1:0] e;
         e = mat[r*4+c];
         return e;
      endfunction

      function logic signed [WORD_BITS-1:0] clamp(logic signed [WIDE-1:0] a, inout bit f);
         logic signed [WIDE-1:0] hi, lo;
         hi = $signed(SMAX);
         lo = -hi - 1;
         if (a > hi) begin
            f = 1;
            return SMAX;
         end
         if (a < lo) begin
            f = 1;
            return SMIN;
         end
         return a[WORD_BITS-1:0];
      endfunction

      function void note_request(logic [2:0] op, logic [3:0] idx, logic [WORD_BITS-1:0] val,
                                 logic signed [WORD_BITS-1:0] x, logic signed [WORD_BITS-1:0] y,
                                 logic signed [WORD_BITS-1:0] z);
         logic signed [WIDE-1:0] acc[3], v[3], m, w, half;
         vertex_result_type r;
         bit tr, f;
         if (op == OP_LOAD) begin
            mat[idx] = val;
            return;
         end
         if (op == OP_SPARE) return;
         v[0] = x; v[1] = y; v[2] = z;
         tr = (op == OP_TAFFINE || op == OP_UNROTATE || op == OP_UNTRANSFORM);
         w = 0;
         f = 0;
         for (int i = 0; i < 3; i++) begin
            acc[i] = 0;
            for (int j = 0; j < 3; j++) begin
               m = tr ? ent(j, i) : ent(i, j);
               acc[i] = acc[i] + m * v[j];
               if (op == OP_UNTRANSFORM) acc[i] = acc[i] - m * ent(j, 3);
            end
            if (op == OP_AFFINE || op == OP_PROJECT) acc[i] = acc[i] + (ent(i, 3) <<< FRAC_BITS);
            if (op == OP_TAFFINE) acc[i] = acc[i] + (ent(3, i) <<< FRAC_BITS);
            if (op == OP_PROJECT) w = w + ent(3, i) * v[i];
         end
         if (op == OP_PROJECT) begin
            w = w + (ent(3, 3) <<< FRAC_BITS);
            if (w == 0) begin
               r.x = 0; r.y = 0; r.z = 0; r.f = 1;
               due.push_back(r);
               return;
            end
            for (int i = 0; i < 3; i++) acc[i] = (acc[i] <<< FRAC_BITS) / w;
         end else begin
            half = 1;
            half = half <<< (FRAC_BITS - 1);
            for (int i = 0; i < 3; i++) acc[i] = (acc[i] + half) >>> FRAC_BITS;
         end
         r.x = clamp(acc[0], f);
         r.y = clamp(acc[1], f);
         r.z = clamp(acc[2], f);
         r.f = f;
         due.push_back(r);
      endfunction

      function void check_result(logic signed [WORD_BITS-1:0] x, logic signed [WORD_BITS-1:0] y,
                                 logic signed [WORD_BITS-1:0] z, logic f);
         vertex_result_type e;
         if (due.size() == 0) begin
            $display("%0t: unexpected result x=%h y=%h z=%h fault=%b", $time, x, y, z, f);
            errors++;
            return;
         end
         e = due.pop_front();
         if (x !== e.x) begin
            $display("%0t: out_x expected %h actual %h", $time, e.x, x);
            errors++;
         end
         if (y !== e.y) begin
            $display("%0t: out_y expected %h actual %h", $time, e.y, y);
            errors++;
         end
         if (z !== e.z) begin
            $display("%0t: out_z expected %h actual %h", $time, e.z, z);
            errors++;
         end
         if (f !== e.f) begin
            $display("%0t: fault expected %b actual %b", $time, e.f, f);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [2:0] req_op = '0;
   logic [3:0] req_entry_index = '0;
   logic signed [WORD_BITS-1:0] req_entry_value = '0;
   logic signed [WORD_BITS-1:0] req_in_x = '0, req_in_y = '0, req_in_z = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [WORD_BITS-1:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic rsp_fault;

   vertex_scoreboard_type sb = new();
   bit calm = 0;
   bit long_hold = 0;
   int hold_left = 0;
   int stall_left = 0;

   vertex_matrix_transform_top dut (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   initial begin
      #(8 * 400000);
      $display("Simulation FAILED");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else begin
         if (rsp_valid && rsp_ready) sb.check_result(rsp_out_x, rsp_out_y, rsp_out_z, rsp_fault);
         if (long_hold) begin
            long_hold = 0;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 7) - 1;
            rsp_ready <= 0;
         end else begin
            rsp_ready <= 1;
         end
      end
   end

   task automatic send(logic [2:0] op, logic [3:0] idx, logic [WORD_BITS-1:0] val,
                       logic [WORD_BITS-1:0] x, logic [WORD_BITS-1:0] y,
                       logic [WORD_BITS-1:0] z);
      req_valid <= 1;
      req_op <= op;
      req_entry_index <= idx;
      req_entry_value <= val;
      req_in_x <= x;
      req_in_y <= y;
      req_in_z <= z;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(op, idx, val, x, y, z);
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.due.size() != 0) @(posedge clock);
      repeat (WORD_BITS + 20) @(posedge clock);
   endtask

   function automatic logic [WORD_BITS-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return SMAX;
         1: return SMIN;
         2: return 0;
         3, 4: return $urandom;
         default: return WORD_BITS'($signed($urandom_range(0, 2 * 4 * 65536)) - 4 * 65536);
      endcase
   endfunction

   task automatic send_random();
      logic [2:0] op;
      op = ($urandom_range(0, 3) == 0) ? OP_LOAD : 3'($urandom_range(1, 7));
      send(op, 4'($urandom), pick_value(), pick_value(), pick_value(), pick_value());
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Identity matrix straight after reset, every vertex op and the spare op code.
      for (int op = 1; op <= 7; op++) send(3'(op), 0, 0, 32'h0001_8000, SMIN, SMAX);
      send(OP_AFFINE, 0, 0, SMAX, SMAX, SMAX);
      send(OP_UNROTATE, 0, 0, 32'hffff_ffff, 1, 32'h0000_8000);
      send(OP_LOAD, 0, SMAX, 0, 0, 0);
      send(OP_LOAD, 5, SMIN, 0, 0, 0);
      send(OP_LOAD, 3, 32'h0002_0000, 0, 0, 0);
      send(OP_LOAD, 7, SMIN, 0, 0, 0);
      send(OP_ROTATE, 0, 0, SMAX, SMIN, SMAX);
      send(OP_UNTRANSFORM, 0, 0, SMIN, SMAX, 1);
      send(OP_TAFFINE, 0, 0, SMAX, SMIN, 0);
      send(OP_PROJECT, 0, 0, 32'h0003_0000, 32'h0001_0000, 0);
      // Zero w in projection.
      send(OP_LOAD, 15, 0, 0, 0, 0);
      send(OP_PROJECT, 0, 0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
      send(OP_LOAD, 12, 32'h0000_0001, 0, 0, 0);
      send(OP_PROJECT, 0, 0, 32'h0000_0003, 0, 0);
      send(OP_PROJECT, 0, 0, 32'hffff_fffd, 0, 0);
      send(OP_AFFINE, 0, 0, 0, 0, 0);
      drain();

      for (int n = 0; n < 500; n++) send_random();
      long_hold = 1;
      for (int n = 0; n < 120; n++) send_random();
      drain();
      for (int n = 0; n < 580; n++) send_random();
      calm = 1;
      for (int n = 0; n < 150; n++) send_random();
      drain();

      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
